// ===== rtl/smc_pkg.sv =====
// shared types, constants and helpers of the stepper move controller
`timescale 1ns / 1ps

package smc_pkg;

  localparam int POS_BITS_DEF = 24;
  localparam int REV_W        = 23;
  localparam int LIM_W        = 24;
  localparam int AMT_W        = 25;
  localparam int STEP_W       = 24;
  localparam int TGT_W        = 32;
  localparam int FUNC_W       = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int IN_DATA_W    = 32;

  localparam logic [REV_W-1:0] REV_RST  = 23'd200;
  localparam logic [LIM_W-1:0] SMIN_RST = 24'h800001;
  localparam logic [LIM_W-1:0] SMAX_RST = 24'h7FFFFF;

  // most negative amount is pulled in by one for move and toward
  localparam logic [AMT_W-1:0] AMT_MOST_NEG = 25'h1000000;
  localparam logic [AMT_W-1:0] AMT_CLAMP    = 25'h1000001;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK, FUNC_MOVE, FUNC_ADD, FUNC_TOWARD, FUNC_HOME, FUNC_ZERO, FUNC_REHOME
  } func_t;

  typedef enum logic [2:0] {
    CAUSE_NONE, CAUSE_DONE, CAUSE_MIN_SW, CAUSE_MAX_SW, CAUSE_SOFT, CAUSE_REHOMED
  } cause_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REV, CFG_SMIN, CFG_SMAX, CFG_INV, CFG_HOME_NEG, CFG_MIN_EN, CFG_MAX_EN
  } cfg_idx_t;

  typedef struct packed {
    logic [REV_W-1:0] rev;
    logic [LIM_W-1:0] smin;
    logic [LIM_W-1:0] smax;
    logic             inv;
    logic             home_neg;
    logic             min_en;
    logic             max_en;
  } cfg_t;

  typedef struct packed {
    logic             run;
    logic             done;
    logic [REV_W-1:0] rem;
  } rem_stat_t;

  function automatic logic [REV_W-1:0] rev_len(input logic [REV_W-1:0] rev);
    rev_len = (rev == '0) ? REV_W'(1) : rev;
  endfunction

  // saturate a two-bit-wider signed sum to the target buffer width
  function automatic logic [TGT_W-1:0] sat32(input logic signed [TGT_W+1:0] v);
    if (v[TGT_W+1:TGT_W-1] == 3'b000 || v[TGT_W+1:TGT_W-1] == 3'b111) begin
      sat32 = v[TGT_W-1:0];
    end else if (v[TGT_W+1]) begin
      sat32 = {1'b1, {(TGT_W-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(TGT_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/smc_rem.sv =====
// serial remainder unit for the home move, one dividend bit per cycle
`timescale 1ns / 1ps

module smc_rem
  import smc_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                ack,
  input  logic [POS_BITS-1:0] dividend,
  input  logic [REV_W-1:0]    divisor,
  output rem_stat_t           stat
);

  localparam int CNT_W = $clog2(POS_BITS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} st_t;

  st_t                 st_r, st_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [POS_BITS-1:0] dvd_r, dvd_nxt;
  logic [REV_W-1:0]    rem_r, rem_nxt;
  logic [REV_W:0]      shifted;
  logic [REV_W:0]      diff;

  assign shifted = {rem_r, dvd_r[POS_BITS-1]};
  assign diff    = shifted - {1'b0, divisor};

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    unique case (st_r)
      ST_IDLE: begin
        if (start) begin
          st_nxt  = ST_RUN;
          cnt_nxt = CNT_W'(POS_BITS);
          dvd_nxt = dividend;
          rem_nxt = '0;
        end
      end
      ST_RUN: begin
        // restoring step: remainder stays below the divisor
        rem_nxt = diff[REV_W] ? shifted[REV_W-1:0] : diff[REV_W-1:0];
        dvd_nxt = {dvd_r[POS_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ack) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.run  = (st_r == ST_RUN);
  assign stat.done = (st_r == ST_DONE);
  assign stat.rem  = rem_r;

endmodule

// ===== rtl/smc_core.sv =====
// motion state and the single-pass update for one word
`timescale 1ns / 1ps

module smc_core
  import smc_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  func_t                      func,
  input  logic signed [AMT_W-1:0]    amount,
  input  logic                       min_switch,
  input  logic                       max_switch,
  input  cfg_t                       cfg,
  input  logic [REV_W-1:0]           rem_mag,
  output logic                       idle,
  output logic signed [POS_BITS-1:0] cur_pos,
  output logic                       step_pulse,
  output logic                       dir_level,
  output logic signed [POS_BITS-1:0] position,
  output logic signed [TGT_W-1:0]    target_left,
  output logic                       busy_res,
  output cause_t                     stop_cause
);

  localparam int CW = (POS_BITS + 1 > LIM_W + 1) ? POS_BITS + 1 : LIM_W + 1;
  localparam int SW = TGT_W + 2;
  localparam logic signed [POS_BITS:0] PONE = (POS_BITS + 1)'(1);

  typedef enum logic [1:0] {MODE_IDLE, MODE_MOVE, MODE_SEEK} mode_t;

  mode_t                       mode_r, mode_nxt;
  logic signed [POS_BITS-1:0]  pos_r, pos_nxt;
  logic [STEP_W-1:0]           steps_r, steps_nxt;
  logic                        neg_r, neg_nxt;
  logic signed [TGT_W-1:0]     tb_r, tb_nxt;
  logic signed [AMT_W-1:0]     cmd_r, cmd_nxt;
  logic                        homing_r, homing_nxt;

  logic [REV_W-1:0]            rev_eff;
  logic signed [LIM_W-1:0]     smin, smax;
  logic                        sw_min, sw_max;

  logic signed [POS_BITS:0]    pos_ext, next_pos;
  logic [POS_BITS:0]           next_abs;
  logic                        soft_out, wrap;
  logic signed [POS_BITS-1:0]  wrapped;

  logic [AMT_W-1:0]            cmd_abs;
  logic [STEP_W-1:0]           taken_u;
  logic signed [AMT_W-1:0]     taken_s;

  logic signed [AMT_W-1:0]     a, a_inv;
  logic [AMT_W-1:0]            a_abs;
  logic signed [TGT_W:0]       tb33, capx, s33;
  logic signed [AMT_W-1:0]     s_tw;

  logic signed [AMT_W-1:0]     s_pre, half, rfull, s_home;

  logic                        start, homing_new;
  logic signed [AMT_W-1:0]     phys, cmd_new;
  logic [AMT_W-1:0]            phys_abs;
  logic                        pulse;
  cause_t                      cause;

  assign rev_eff = rev_len(cfg.rev);
  assign smin    = cfg.smin;
  assign smax    = cfg.smax;
  // min has priority over max
  assign sw_min  = cfg.min_en && min_switch;
  assign sw_max  = !sw_min && cfg.max_en && max_switch;

  // next position of a step, before wrap
  assign pos_ext  = (POS_BITS + 1)'(pos_r);
  assign next_pos = neg_r ? pos_ext - PONE : pos_ext + PONE;
  assign next_abs = next_pos[POS_BITS] ? -next_pos : next_pos;
  assign soft_out = (CW'(next_pos) < CW'(smin)) || (CW'(next_pos) > CW'(smax));
  assign wrap     = CW'(next_abs) >= CW'(rev_eff);
  assign wrapped  = wrap ? '0 : next_pos[POS_BITS-1:0];

  // steps already taken, signed in command frame
  assign cmd_abs = cmd_r[AMT_W-1] ? -cmd_r : cmd_r;
  assign taken_u = cmd_abs[STEP_W-1:0] - steps_r;
  assign taken_s = cmd_r[AMT_W-1] ? -signed'({1'b0, taken_u}) : signed'({1'b0, taken_u});

  assign a     = (amount == AMT_MOST_NEG) ? signed'(AMT_CLAMP) : amount;
  assign a_inv = -a;
  assign a_abs = a[AMT_W-1] ? a_inv : a;

  // toward target: buffer clipped to plus or minus the cap
  assign tb33 = (TGT_W + 1)'(tb_r);
  assign capx = signed'((TGT_W + 1)'(a_abs[STEP_W-1:0]));
  always_comb begin
    if (tb_r[TGT_W-1]) begin
      s33 = (tb33 < -capx) ? -capx : tb33;
    end else begin
      s33 = (tb33 > capx) ? capx : tb33;
    end
  end
  assign s_tw = s33[AMT_W-1:0];

  // home: back to a whole revolution; the shorter way is taken only from a negative position
  assign s_pre  = pos_r[POS_BITS-1] ? signed'({2'b00, rem_mag}) : -signed'({2'b00, rem_mag});
  assign half   = signed'({3'b000, rev_eff[REV_W-1:1]});
  assign rfull  = signed'({2'b00, rev_eff});
  assign s_home = (s_pre > half) ? s_pre - rfull : s_pre;

  assign phys_abs = phys[AMT_W-1] ? -phys : phys;

  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    steps_nxt  = steps_r;
    neg_nxt    = neg_r;
    tb_nxt     = tb_r;
    cmd_nxt    = cmd_r;
    homing_nxt = homing_r;
    pulse      = 1'b0;
    cause      = CAUSE_NONE;
    start      = 1'b0;
    homing_new = 1'b0;
    phys       = '0;
    cmd_new    = '0;
    if (func == FUNC_TICK) begin
      if (mode_r == MODE_MOVE) begin
        priority if (sw_min && neg_r) begin
          tb_nxt    = homing_r ? TGT_W'(pos_r) : '0;
          mode_nxt  = MODE_IDLE;
          steps_nxt = '0;
          cause     = CAUSE_MIN_SW;
        end else if (sw_max && !neg_r) begin
          tb_nxt    = homing_r ? TGT_W'(pos_r) : '0;
          mode_nxt  = MODE_IDLE;
          steps_nxt = '0;
          cause     = CAUSE_MAX_SW;
        end else if (soft_out) begin
          tb_nxt    = homing_r ? TGT_W'(pos_r) : sat32(SW'(tb_r) - SW'(taken_s));
          mode_nxt  = MODE_IDLE;
          steps_nxt = '0;
          cause     = CAUSE_SOFT;
        end else begin
          pulse     = 1'b1;
          pos_nxt   = wrapped;
          steps_nxt = steps_r - STEP_W'(1);
          if (steps_r == STEP_W'(1)) begin
            tb_nxt    = homing_r ? TGT_W'(wrapped) : sat32(SW'(tb_r) - SW'(cmd_r));
            mode_nxt  = MODE_IDLE;
            steps_nxt = '0;
            cause     = CAUSE_DONE;
          end
        end
      end else if (mode_r == MODE_SEEK) begin
        pulse = 1'b1;
        if (sw_min || sw_max) begin
          pos_nxt  = '0;
          tb_nxt   = '0;
          mode_nxt = MODE_IDLE;
          cause    = CAUSE_REHOMED;
        end
      end
    end else if (mode_r == MODE_IDLE) begin
      unique case (func)
        FUNC_MOVE: begin
          start   = 1'b1;
          phys    = cfg.inv ? a_inv : a;
          cmd_new = a;
        end
        FUNC_ADD: begin
          tb_nxt = sat32(SW'(tb_r) + SW'(amount));
        end
        FUNC_TOWARD: begin
          if (tb_r != '0) begin
            start   = 1'b1;
            phys    = cfg.inv ? -s_tw : s_tw;
            cmd_new = s_tw;
          end
        end
        FUNC_HOME: begin
          tb_nxt     = '0;
          start      = 1'b1;
          phys       = s_home;
          cmd_new    = s_home;
          homing_new = 1'b1;
        end
        FUNC_ZERO: begin
          pos_nxt = '0;
        end
        FUNC_REHOME: begin
          neg_nxt  = cfg.home_neg ^ cfg.inv;
          mode_nxt = MODE_SEEK;
        end
        default: ;
      endcase
      if (start) begin
        neg_nxt    = phys[AMT_W-1];
        steps_nxt  = phys_abs[STEP_W-1:0];
        cmd_nxt    = cmd_new;
        homing_nxt = homing_new;
        if (phys == '0) begin
          // empty move ends at once; buffer untouched unless homing
          if (homing_new) begin
            tb_nxt = TGT_W'(pos_r);
          end
          mode_nxt  = MODE_IDLE;
          steps_nxt = '0;
          cause     = CAUSE_DONE;
        end else begin
          mode_nxt = MODE_MOVE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= '0;
      steps_r  <= '0;
      neg_r    <= 1'b0;
      tb_r     <= '0;
      cmd_r    <= '0;
      homing_r <= 1'b0;
    end else if (go) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      steps_r  <= steps_nxt;
      neg_r    <= neg_nxt;
      tb_r     <= tb_nxt;
      cmd_r    <= cmd_nxt;
      homing_r <= homing_nxt;
    end
  end

  assign idle        = (mode_r == MODE_IDLE);
  assign cur_pos     = pos_r;
  assign step_pulse  = pulse;
  assign dir_level   = neg_nxt;
  assign position    = pos_nxt;
  assign target_left = tb_nxt;
  assign busy_res    = (mode_nxt != MODE_IDLE);
  assign stop_cause  = cause;

endmodule

// ===== rtl/smc_obuf.sv =====
// two-entry result register with skid stage
`timescale 1ns / 1ps

module smc_obuf #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         space,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         main_v_r, skid_v_r;
  logic [W-1:0] main_r, skid_r;
  logic         pop;

  assign pop = main_v_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_v_r) begin
          main_r   <= skid_r;
          skid_v_r <= push;
          skid_r   <= din;
        end else begin
          main_v_r <= push;
          main_r   <= din;
        end
      end else if (!main_v_r) begin
        main_v_r <= push;
        main_r   <= din;
      end else if (push) begin
        skid_v_r <= 1'b1;
        skid_r   <= din;
      end
    end
  end

  assign space     = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

endmodule

// ===== rtl/stepper_move_controller.sv =====
// top level: input register, motion core, home remainder unit, result buffer
// path: an accepted word passes the input register and the core into the result buffer
// throughput: one word per cycle while the result buffer has room; a home command
//   while idle waits in the input register for the serial remainder unit
// reset: rst_n synchronous, active low; clears motion state, buffers and
//   loads the configuration defaults, no clearing pass
`timescale 1ns / 1ps

module stepper_move_controller
  import smc_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // amount[24:0], min_switch[25], max_switch[26], zero fill
  input  logic [IN_DATA_W-1:0]                     in_tdata,
  // func
  input  logic [FUNC_W-1:0]                        in_tuser,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // step_pulse, dir_level, position, target_left, busy_res, stop_cause, zero fill
  output logic [((POS_BITS + TGT_W + 6 + 7) / 8) * 8 - 1:0] out_tdata,
  input  logic                                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]                     cfg_index,
  input  logic [CFG_DATA_W-1:0]                    cfg_wdata
);

  localparam int OUT_W = ((POS_BITS + TGT_W + 6 + 7) / 8) * 8;

  // configuration registers
  logic [REV_W-1:0] rev_r;
  logic [LIM_W-1:0] smin_r, smax_r;
  logic             inv_r, home_neg_r, min_en_r, max_en_r;
  cfg_t             cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rev_r      <= REV_RST;
      smin_r     <= SMIN_RST;
      smax_r     <= SMAX_RST;
      inv_r      <= 1'b0;
      home_neg_r <= 1'b1;
      min_en_r   <= 1'b0;
      max_en_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_REV:      rev_r      <= cfg_wdata[REV_W-1:0];
        CFG_SMIN:     smin_r     <= cfg_wdata[LIM_W-1:0];
        CFG_SMAX:     smax_r     <= cfg_wdata[LIM_W-1:0];
        CFG_INV:      inv_r      <= cfg_wdata[0];
        CFG_HOME_NEG: home_neg_r <= cfg_wdata[0];
        CFG_MIN_EN:   min_en_r   <= cfg_wdata[0];
        CFG_MAX_EN:   max_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg.rev      = rev_r;
  assign cfg.smin     = smin_r;
  assign cfg.smax     = smax_r;
  assign cfg.inv      = inv_r;
  assign cfg.home_neg = home_neg_r;
  assign cfg.min_en   = min_en_r;
  assign cfg.max_en   = max_en_r;

  // input register
  logic                    s1_v_r;
  func_t                   s1_func_r;
  logic signed [AMT_W-1:0] s1_amount_r;
  logic                    s1_min_r, s1_max_r;
  logic                    in_acc, s1_go;

  logic                    core_idle;
  logic signed [POS_BITS-1:0] core_pos;
  logic [POS_BITS-1:0]     pos_mag;
  rem_stat_t               rem_stat;
  logic                    home_need, home_wait, rem_start, rem_ack;

  logic                       res_pulse, res_dir, res_busy;
  logic signed [POS_BITS-1:0] res_pos;
  logic signed [TGT_W-1:0]    res_tgt;
  cause_t                     res_cause;
  logic                       obuf_space;
  logic [OUT_W-1:0]           res_word;

  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
    if (in_acc) begin
      s1_func_r   <= func_t'(in_tuser);
      s1_amount_r <= signed'(in_tdata[AMT_W-1:0]);
      s1_min_r    <= in_tdata[AMT_W];
      s1_max_r    <= in_tdata[AMT_W+1];
    end
  end

  // a home command taken while idle needs the remainder first
  assign home_need = (s1_func_r == FUNC_HOME) && core_idle;
  assign home_wait = home_need && !rem_stat.done;
  assign rem_start = s1_v_r && home_need && !rem_stat.run && !rem_stat.done;
  assign s1_go     = s1_v_r && obuf_space && !home_wait;
  assign rem_ack   = s1_go && home_need;
  assign in_tready = !s1_v_r || s1_go;

  assign pos_mag = core_pos[POS_BITS-1] ? -core_pos : core_pos;

  smc_rem #(
    .POS_BITS (POS_BITS)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .ack      (rem_ack),
    .dividend (pos_mag),
    .divisor  (rev_len(rev_r)),
    .stat     (rem_stat)
  );

  smc_core #(
    .POS_BITS (POS_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (s1_go),
    .func        (s1_func_r),
    .amount      (s1_amount_r),
    .min_switch  (s1_min_r),
    .max_switch  (s1_max_r),
    .cfg         (cfg),
    .rem_mag     (rem_stat.rem),
    .idle        (core_idle),
    .cur_pos     (core_pos),
    .step_pulse  (res_pulse),
    .dir_level   (res_dir),
    .position    (res_pos),
    .target_left (res_tgt),
    .busy_res    (res_busy),
    .stop_cause  (res_cause)
  );

  assign res_word = OUT_W'({res_cause, res_busy, res_tgt, res_pos, res_dir, res_pulse});

  smc_obuf #(
    .W (OUT_W)
  ) u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_go),
    .din       (res_word),
    .space     (obuf_space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

  // a word is only pushed when the skid stage is free
  a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |-> obuf_space)
    else $error("result pushed with no room");

  // nothing advances or enters while the remainder is being worked out
  a_rem_holds: assert property (@(posedge clk) disable iff (!rst_n)
    rem_stat.run |-> (!s1_go && !in_tready))
    else $error("word moved during remainder");

  // a reported end of motion leaves the block idle
  a_cause_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && res_cause != CAUSE_NONE) |=> core_idle)
    else $error("stop cause with motion still active");

  // the remainder is consumed by the very home command that asked for it
  a_rem_once: assert property (@(posedge clk) disable iff (!rst_n)
    rem_ack |=> !rem_stat.done)
    else $error("remainder left pending");

endmodule

// ===== bench/smc_motor_checker.sv =====
// stepper controller checker: predicts each result word and compares it with the block
`timescale 1ns / 1ps

module smc_motor_checker
  import smc_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF,
  parameter int OUT_W    = ((POS_BITS + TGT_W + 6 + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // amount[24:0], min_switch[25], max_switch[26], zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func
  input  logic [FUNC_W-1:0]     in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // step_pulse, dir_level, position, target_left, busy_res, stop_cause, zero fill
  input  logic [OUT_W-1:0]      out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fault_cnt
);

  localparam longint AMT_LIMIT = 16777215;
  localparam int     POS_LSB   = 2;
  localparam int     TGT_LSB   = POS_BITS + 2;
  localparam int     BUSY_BIT  = POS_BITS + TGT_W + 2;
  localparam int     CAUSE_LSB = POS_BITS + TGT_W + 3;

  typedef enum logic [1:0] {MOTOR_IDLE, MOTOR_STEPPING, MOTOR_SEEKING} motor_mode_t;

  typedef struct {
    bit     pulse;
    bit     dir;
    longint pos;
    longint tgt;
    bit     busy;
    cause_t cause;
  } motor_word_t;

  // configuration copy
  longint spr, lo_lim, hi_lim;
  bit     inv_dir, home_neg, min_en, max_en;

  // motion state
  longint      pos_q, left_q, tgt_q, cmd_q;
  bit          neg_q, homing_q;
  motor_mode_t mode_q;

  motor_word_t motor_due_q[$];
  int          mism_cnt;
  int          pending;

  // words still owed count against the run once it ends
  assign fault_cnt = mism_cnt + pending;

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint pos_wrap(input longint v);
    logic signed [POS_BITS-1:0] t;
    t = v[POS_BITS-1:0];
    return longint'(t);
  endfunction

  function automatic void stop_motion(input longint taken, input bit clear);
    if (homing_q) tgt_q = pos_q;
    else if (clear) tgt_q = 0;
    else tgt_q = clip32(tgt_q - taken);
    mode_q = MOTOR_IDLE;
    left_q = 0;
  endfunction

  function automatic cause_t start_motion(input longint phys, input longint cmd,
                                          input bit homing);
    neg_q    = phys < 0;
    left_q   = mag(phys);
    cmd_q    = cmd;
    homing_q = homing;
    if (left_q == 0) begin
      stop_motion(cmd, 1'b0);
      return CAUSE_DONE;
    end
    mode_q = MOTOR_STEPPING;
    return CAUSE_NONE;
  endfunction

  function automatic motor_word_t motor_advance(input logic [FUNC_W-1:0] fn,
                                                input longint amount,
                                                input bit mn, input bit mx);
    motor_word_t w;
    bit          pulse, hit_min, hit_max;
    cause_t      cause;
    longint      nxt, taken, a, cap, s, r;
    pulse   = 1'b0;
    cause   = CAUSE_NONE;
    r       = (spr == 0) ? 1 : spr;
    a       = (amount < -AMT_LIMIT) ? -AMT_LIMIT : amount;
    // min switch wins when both read triggered
    hit_min = min_en && mn;
    hit_max = !hit_min && max_en && mx;
    if (fn == FUNC_TICK) begin
      if (mode_q == MOTOR_STEPPING) begin
        taken = mag(cmd_q) - left_q;
        if (cmd_q < 0) taken = -taken;
        nxt = pos_q + (neg_q ? -1 : 1);
        if (hit_min && neg_q) begin
          stop_motion(0, 1'b1);
          cause = CAUSE_MIN_SW;
        end else if (hit_max && !neg_q) begin
          stop_motion(0, 1'b1);
          cause = CAUSE_MAX_SW;
        end else if (nxt < lo_lim || nxt > hi_lim) begin
          stop_motion(taken, 1'b0);
          cause = CAUSE_SOFT;
        end else begin
          pulse = 1'b1;
          if (mag(nxt) >= r) nxt = 0;
          pos_q = pos_wrap(nxt);
          left_q--;
          if (left_q == 0) begin
            stop_motion(cmd_q, 1'b0);
            cause = CAUSE_DONE;
          end
        end
      end else if (mode_q == MOTOR_SEEKING) begin
        pulse = 1'b1;
        if (hit_min || hit_max) begin
          pos_q  = 0;
          tgt_q  = 0;
          mode_q = MOTOR_IDLE;
          cause  = CAUSE_REHOMED;
        end
      end
    end else if (mode_q == MOTOR_IDLE) begin
      case (fn)
        FUNC_MOVE: begin
          cause = start_motion(inv_dir ? -a : a, a, 1'b0);
        end
        FUNC_ADD: begin
          tgt_q = clip32(tgt_q + amount);
        end
        FUNC_TOWARD: begin
          cap = mag(a);
          if (tgt_q != 0) begin
            if (tgt_q < 0) s = (tgt_q < -cap) ? -cap : tgt_q;
            else s = (tgt_q > cap) ? cap : tgt_q;
            cause = start_motion(inv_dir ? -s : s, s, 1'b0);
          end
        end
        FUNC_HOME: begin
          // step back to a revolution mark, taking the shorter way only from a negative position
          s = -(pos_q % r);
          if (s > r / 2) s = s - r;
          tgt_q = 0;
          cause = start_motion(s, s, 1'b1);
        end
        FUNC_ZERO: begin
          pos_q = 0;
        end
        FUNC_REHOME: begin
          neg_q  = home_neg ^ inv_dir;
          mode_q = MOTOR_SEEKING;
        end
        default: begin
        end
      endcase
    end
    w.pulse = pulse;
    w.dir   = neg_q;
    w.pos   = pos_q;
    w.tgt   = tgt_q;
    w.busy  = mode_q != MOTOR_IDLE;
    w.cause = cause;
    return w;
  endfunction

  function automatic bit same(input string nm, input longint e, input longint a);
    if (e == a) return 1'b1;
    $display("%0t ns %s mismatch: expected %0d actual %0d", $time, nm, e, a);
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    motor_word_t w;
    bit          ok;
    if (!rst_n) begin
      spr      = REV_RST;
      lo_lim   = longint'($signed(SMIN_RST));
      hi_lim   = longint'($signed(SMAX_RST));
      inv_dir  = 1'b0;
      home_neg = 1'b1;
      min_en   = 1'b0;
      max_en   = 1'b0;
      pos_q    = 0;
      left_q   = 0;
      tgt_q    = 0;
      cmd_q    = 0;
      neg_q    = 1'b0;
      homing_q = 1'b0;
      mode_q   = MOTOR_IDLE;
      motor_due_q.delete();
      pending  = 0;
      mism_cnt = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (motor_due_q.size() == 0) begin
          $display("%0t ns result word with nothing expected: expected none actual %h",
                   $time, out_tdata);
          mism_cnt++;
        end else begin
          w = motor_due_q.pop_front();
          pending = motor_due_q.size();
          ok = same("step_pulse", w.pulse, out_tdata[0]);
          ok &= same("dir_level", w.dir, out_tdata[1]);
          ok &= same("position", w.pos, longint'($signed(out_tdata[POS_LSB +: POS_BITS])));
          ok &= same("target_left", w.tgt, longint'($signed(out_tdata[TGT_LSB +: TGT_W])));
          ok &= same("busy_res", w.busy, out_tdata[BUSY_BIT]);
          ok &= same("stop_cause", longint'(w.cause), out_tdata[CAUSE_LSB +: 3]);
          if (!ok) mism_cnt++;
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_REV:      spr      = cfg_wdata[REV_W-1:0];
          CFG_SMIN:     lo_lim   = longint'($signed(cfg_wdata[LIM_W-1:0]));
          CFG_SMAX:     hi_lim   = longint'($signed(cfg_wdata[LIM_W-1:0]));
          CFG_INV:      inv_dir  = cfg_wdata[0];
          CFG_HOME_NEG: home_neg = cfg_wdata[0];
          CFG_MIN_EN:   min_en   = cfg_wdata[0];
          CFG_MAX_EN:   max_en   = cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (in_tvalid && in_tready) begin
        motor_due_q.push_back(motor_advance(in_tuser,
                                            longint'($signed(in_tdata[AMT_W-1:0])),
                                            in_tdata[AMT_W], in_tdata[AMT_W+1]));
        pending = motor_due_q.size();
      end
    end
  end

endmodule

// ===== bench/stepper_move_controller_tb.sv =====
// stepper controller testbench top: clock, reset, stimulus phases and verdict
`timescale 1ns / 1ps

module stepper_move_controller_tb;
  import smc_pkg::*;

  localparam int POS_BITS    = POS_BITS_DEF;
  localparam int OUT_W       = ((POS_BITS + TGT_W + 6 + 7) / 8) * 8;
  localparam int BUSY_BIT    = POS_BITS + TGT_W + 2;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_WORDS = 120;
  localparam logic [FUNC_W-1:0]      FUNC_SPARE = 3'd7;
  localparam logic signed [AMT_W-1:0] AMT_TOP    = 25'sh0FFFFFF;
  localparam logic signed [AMT_W-1:0] AMT_BOTTOM = AMT_MOST_NEG;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [FUNC_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    fault_cnt;

  int words_sent = 0;
  int words_back = 0;
  bit last_busy = 1'b0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cyc = 0;
  int rev_l = 200;
  bit big_ok = 1'b0;
  bit seek_ok = 1'b0;

  stepper_move_controller #(.POS_BITS(POS_BITS)) i_dut (.*);

  smc_motor_checker #(.POS_BITS(POS_BITS)) i_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      words_back <= words_back + 1;
      last_busy  <= out_tdata[BUSY_BIT];
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cyc <= 0;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
      if (quiet_cyc >= STALL_LIMIT) begin
        $display("%0t ns watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic bit chance(input int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic logic signed [AMT_W-1:0] small_count(input int hi);
    int m;
    m = $urandom_range(hi, 0);
    return AMT_W'(chance(50) ? -m : m);
  endfunction

  function automatic int count_mag(input logic signed [AMT_W-1:0] a);
    int k;
    k = int'(a);
    return (k < 0) ? -k : k;
  endfunction

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [AMT_W-1:0] amt,
                           input bit mn, input bit mx);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {5'b0, mx, mn, amt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_ticks(input int n, input int sw_pct);
    repeat (n) send_word(FUNC_TICK, AMT_W'($urandom), chance(sw_pct), chance(sw_pct));
  endtask

  // one switch at a time so a move in either direction sees its own switch
  task automatic send_hunt_ticks(input int n);
    for (int i = 0; i < n; i++) send_word(FUNC_TICK, AMT_W'($urandom), i[0] == 0, i[0] == 1);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (words_back != words_sent);
  endtask

  task automatic settle();
    wait_drained();
    while (last_busy) begin
      send_hunt_ticks(8);
      wait_drained();
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic load_setting(input int rev, input int lo, input int hi, input bit inv,
                              input bit hneg, input bit mne, input bit mxe);
    write_reg(CFG_REV, CFG_DATA_W'(rev));
    write_reg(CFG_SMIN, CFG_DATA_W'(lo));
    write_reg(CFG_SMAX, CFG_DATA_W'(hi));
    write_reg(CFG_INV, CFG_DATA_W'(inv));
    write_reg(CFG_HOME_NEG, CFG_DATA_W'(hneg));
    write_reg(CFG_MIN_EN, CFG_DATA_W'(mne));
    write_reg(CFG_MAX_EN, CFG_DATA_W'(mxe));
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    rev_l   = (rev == 0) ? 1 : rev;
    // very long moves only where a switch or a tight soft range ends them
    big_ok  = (mne && mxe) || (lo > -rev_l && hi < rev_l);
    seek_ok = mne || mxe;
  endtask

  task automatic run_mix(input int n_words);
    int                        base, pick, k;
    logic signed [AMT_W-1:0]   amt;
    base = words_sent;
    while (words_sent - base < n_words) begin
      pick = $urandom_range(99, 0);
      if (pick < 28) begin
        amt = small_count(40);
        send_word(FUNC_MOVE, amt, chance(50), chance(50));
        send_ticks(count_mag(amt) + $urandom_range(2, 0), 3);
      end else if (pick < 40) begin
        amt = chance(50) ? AMT_W'($urandom) : small_count(60);
        send_word(FUNC_ADD, amt, chance(50), chance(50));
      end else if (pick < 54) begin
        amt = (big_ok && chance(10)) ? AMT_BOTTOM : small_count(40);
        send_word(FUNC_TOWARD, amt, chance(50), chance(50));
        k = count_mag(amt);
        send_ticks($urandom_range((k > 45) ? 45 : k + 1, 0), 3);
      end else if (pick < 62) begin
        send_word(FUNC_HOME, AMT_W'($urandom), chance(50), chance(50));
        k = rev_l / 2;
        send_ticks($urandom_range(((k > 60) ? 60 : k) + 1, 0), 3);
      end else if (pick < 67) begin
        send_word(FUNC_ZERO, AMT_W'($urandom), chance(50), chance(50));
      end else if (pick < 73) begin
        if (seek_ok) begin
          send_word(FUNC_REHOME, AMT_W'($urandom), chance(50), chance(50));
          send_ticks($urandom_range(12, 1), 15);
        end
      end else if (pick < 79) begin
        if (big_ok) begin
          case ($urandom_range(2, 0))
            0:       amt = AMT_TOP;
            1:       amt = AMT_BOTTOM;
            default: amt = AMT_W'($urandom) | 25'h0F00000;
          endcase
          send_word(FUNC_MOVE, amt, chance(50), chance(50));
          send_hunt_ticks(12);
        end
      end else if (pick < 85) begin
        send_word(chance(50) ? FUNC_SPARE : FUNC_TICK, AMT_W'($urandom),
                  chance(50), chance(50));
      end else begin
        send_ticks($urandom_range(6, 1), 20);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed words at the reset configuration
    send_word(FUNC_TICK, AMT_W'(0), 1'b0, 1'b0);
    send_word(FUNC_SPARE, AMT_TOP, 1'b1, 1'b1);
    send_word(FUNC_MOVE, AMT_W'(0), 1'b0, 1'b0);
    send_word(FUNC_MOVE, AMT_W'(2), 1'b0, 1'b0);
    send_ticks(2, 0);
    send_word(FUNC_ADD, AMT_TOP, 1'b0, 1'b0);
    send_word(FUNC_ADD, AMT_BOTTOM, 1'b0, 1'b0);
    send_word(FUNC_TOWARD, AMT_W'(0), 1'b0, 1'b0);
    send_word(FUNC_TOWARD, AMT_BOTTOM, 1'b0, 1'b0);
    // command while a move runs is dropped
    send_word(FUNC_ADD, AMT_W'(5), 1'b0, 1'b0);
    send_word(FUNC_TICK, AMT_W'(0), 1'b1, 1'b1);
    send_word(FUNC_TOWARD, AMT_W'(3), 1'b0, 1'b0);
    send_word(FUNC_MOVE, AMT_W'(-3), 1'b0, 1'b0);
    send_ticks(3, 0);
    send_word(FUNC_HOME, AMT_W'(0), 1'b0, 1'b0);
    send_ticks(4, 0);
    send_word(FUNC_ZERO, AMT_W'(0), 1'b0, 1'b0);
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 81; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 81; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      case (p)
        0: load_setting(200, -8388607, 8388607, 1'b0, 1'b1, 1'b1, 1'b1);
        1: load_setting(1, -8388608, 8388607, 1'b1, 1'b0, 1'b1, 1'b0);
        2: load_setting(8388607, -20, 20, 1'b0, 1'b0, 1'b0, 1'b1);
        3: load_setting(0, 0, 0, 1'b1, 1'b1, 1'b1, 1'b1);
        4: load_setting(7, -5, 3, 1'b0, 1'b1, 1'b0, 1'b0);
        default: load_setting($urandom_range(300, 2), -$urandom_range(400, 0),
                              $urandom_range(400, 0), $urandom_range(1, 0),
                              $urandom_range(1, 0), $urandom_range(1, 0),
                              $urandom_range(1, 0));
      endcase
      if (p == 0) begin
        // drive the target buffer into both saturation rails
        repeat (140) send_word(FUNC_ADD, AMT_TOP, 1'b0, 1'b0);
        repeat (270) send_word(FUNC_ADD, AMT_BOTTOM, 1'b1, 1'b1);
      end
      run_mix(PHASE_WORDS);
      settle();
    end

    // a switch seek with no switch enabled never ends, so it closes the run
    send_idle_pct = 19;
    stall_pct     = 19;
    load_setting(200, -8388607, 8388607, 1'b0, 1'b1, 1'b0, 1'b0);
    send_word(FUNC_REHOME, AMT_W'(0), 1'b0, 1'b0);
    send_ticks(20, 50);
    wait_drained();
    repeat (8) @(posedge clk);

    if (fault_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== stepper_move_controller.f =====
rtl/smc_pkg.sv
rtl/smc_rem.sv
rtl/smc_core.sv
rtl/smc_obuf.sv
rtl/stepper_move_controller.sv
bench/smc_motor_checker.sv
bench/stepper_move_controller_tb.sv
